FILE: sv/tsfe_pkg.sv
// tsfe_pkg: shared types and constants of the tagged scalar field encoder
// no dependencies; imported by tsfe_encode, tsfe_serial and the top level
package tsfe_pkg;

	localparam int TAG_W      = 16;
	localparam int KIND_W     = 3;
	localparam int RAW_W      = 64;
	localparam int BYTE_W     = 8;
	localparam int MAX_BYTES  = 10;
	localparam int FRAME_W    = MAX_BYTES * BYTE_W;
	localparam int COUNT_W    = $clog2(MAX_BYTES + 1);
	localparam int IN_DATA_W  = ((TAG_W + KIND_W + RAW_W + 7) / 8) * 8;

	localparam logic [7:0] LONG_TAG_MARK   = 8'hF0;
	localparam logic [7:0] SHORT_TAG_LIMIT = 8'd15;

	// value kinds on the input
	typedef enum logic [KIND_W-1:0] {
		KIND_U8     = 3'd0,
		KIND_S16    = 3'd1,
		KIND_S32    = 3'd2,
		KIND_S64    = 3'd3,
		KIND_FLOAT  = 3'd4,
		KIND_DOUBLE = 3'd5
	} kind_t;

	// type codes in the head byte
	typedef enum logic [3:0] {
		TYPE_BYTE   = 4'd0,
		TYPE_SHORT  = 4'd1,
		TYPE_INT    = 4'd2,
		TYPE_LONG   = 4'd3,
		TYPE_FLOAT  = 4'd4,
		TYPE_DOUBLE = 4'd5,
		TYPE_ZERO   = 4'd12
	} type_code_t;

	typedef struct packed {
		logic [TAG_W-1:0]  field_tag;
		logic [KIND_W-1:0] value_kind;
		logic [RAW_W-1:0]  raw_value;
	} field_t;

	// encoded field: bytes in send order from the lowest bits up
	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic [COUNT_W-1:0] count;
		logic               tag_error;
	} frame_t;

endpackage

FILE: sv/tagged_scalar_field_encoder_core.sv
// tagged_scalar_field_encoder_core: top level of the tagged scalar field encoder
// depends on tsfe_pkg, tsfe_encode and tsfe_serial
//
// channel  | dir | tdata                                   | tlast      | tuser
// s_axis   | in  | field_tag, value_kind, raw_value (88b)  | -          | -
// m_axis   | out | out_byte (8b)                           | last_byte  | tag_error
//
// a field is held in the input register, then sent as one word per encoded byte:
// 1 to 10 words per field, one byte per cycle from the output register unless it is stalled
// the next field is taken while the current one is still being sent
// reset clears the valid flags only; the data registers hold no reset
// a stalled output holds its word; input stalls only once both stages are full
module tagged_scalar_field_encoder_core
	import tsfe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input word
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// field_tag [15:0], value_kind [18:16], raw_value [82:19], zero pad [87:83]
	input  logic [IN_DATA_W-1:0] s_axis_tdata,
	// result word
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// out_byte [7:0]
	output logic [BYTE_W-1:0]    m_axis_tdata,
	// last_byte of the field
	output logic                 m_axis_tlast,
	// tag_error [0]
	output logic                 m_axis_tuser
);

	field_t field_s1;
	logic   valid_s1;
	frame_t enc;
	logic   load_ready;
	logic   load;

	// the input register moves on whenever the frame register can take it
	assign load          = valid_s1 && load_ready;
	assign s_axis_tready = !valid_s1 || load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			field_s1.field_tag  <= s_axis_tdata[TAG_W-1:0];
			field_s1.value_kind <= s_axis_tdata[TAG_W+KIND_W-1:TAG_W];
			field_s1.raw_value  <= s_axis_tdata[TAG_W+KIND_W+RAW_W-1:TAG_W+KIND_W];
		end
	end

	// head, tag and payload bytes built straight from the input register
	tsfe_encode u_encode (
		.field (field_s1),
		.enc   (enc)
	);

	tsfe_serial u_serial (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.enc           (enc),
		.load_ready    (load_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

FILE: sv/tsfe_encode.sv
// tsfe_encode: combinational encoding of one scalar field into a byte frame
// depends on tsfe_pkg
module tsfe_encode
	import tsfe_pkg::*;
(
	input  field_t field,
	output frame_t enc
);

	logic [RAW_W-1:0]   s_val;
	logic [RAW_W-1:0]   payload;
	type_code_t         type_code;
	logic [3:0]         nbytes;
	logic               fits32;
	logic               fits16;
	logic               fits8;
	logic               short_tag;
	logic [BYTE_W-1:0]  head0;
	logic               bad;

	always_comb begin
		unique case (field.value_kind)
			KIND_U8:  s_val = {56'd0, field.raw_value[7:0]};
			KIND_S16: s_val = {{48{field.raw_value[15]}}, field.raw_value[15:0]};
			KIND_S32: s_val = {{32{field.raw_value[31]}}, field.raw_value[31:0]};
			default:  s_val = field.raw_value;
		endcase
	end

	// signed range checks: upper bits all copies of the sign
	assign fits32 = (&s_val[63:31]) | ~(|s_val[63:31]);
	assign fits16 = (&s_val[63:15]) | ~(|s_val[63:15]);
	assign fits8  = (&s_val[63:7])  | ~(|s_val[63:7]);

	always_comb begin
		payload = s_val;
		priority if (field.value_kind == KIND_FLOAT) begin
			type_code = TYPE_FLOAT;
			nbytes    = 4'd4;
			payload   = {32'd0, field.raw_value[31:0]};
		end else if (field.value_kind == KIND_DOUBLE) begin
			type_code = TYPE_DOUBLE;
			nbytes    = 4'd8;
			payload   = field.raw_value;
		end else if (field.value_kind >= KIND_S64 && !fits32) begin
			type_code = TYPE_LONG;
			nbytes    = 4'd8;
		end else if (field.value_kind >= KIND_S32 && !fits16) begin
			type_code = TYPE_INT;
			nbytes    = 4'd4;
		end else if (field.value_kind >= KIND_S16 && !fits8) begin
			type_code = TYPE_SHORT;
			nbytes    = 4'd2;
		end else if (s_val[7:0] == 8'd0) begin
			type_code = TYPE_ZERO;
			nbytes    = 4'd0;
		end else begin
			type_code = TYPE_BYTE;
			nbytes    = 4'd1;
		end
	end

	assign bad       = (field.field_tag[15:8] != 8'd0) || (field.value_kind > KIND_DOUBLE);
	assign short_tag = field.field_tag[7:0] < SHORT_TAG_LIMIT;
	assign head0     = short_tag ? {field.field_tag[3:0], type_code}
	                             : (LONG_TAG_MARK | {4'd0, type_code});

	always_comb begin
		enc.tag_error = bad;
		if (bad) begin
			enc.frame = '0;
			enc.count = COUNT_W'(1);
		end else if (short_tag) begin
			enc.frame = {8'd0, payload, head0};
			enc.count = COUNT_W'(nbytes) + COUNT_W'(1);
		end else begin
			enc.frame = {payload, field.field_tag[7:0], head0};
			enc.count = COUNT_W'(nbytes) + COUNT_W'(2);
		end
	end

endmodule

FILE: sv/tsfe_serial.sv
// tsfe_serial: frame register that sends an encoded field one byte per word
// depends on tsfe_pkg
module tsfe_serial
	import tsfe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  frame_t            enc,
	output logic              load_ready,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [BYTE_W-1:0] m_axis_tdata,
	output logic              m_axis_tlast,
	output logic              m_axis_tuser
);

	logic [FRAME_W-1:0] frame_q;
	logic [COUNT_W-1:0] left_q;
	logic               err_q;
	logic               take;

	assign m_axis_tvalid = left_q != '0;
	assign m_axis_tlast  = left_q == COUNT_W'(1);
	assign m_axis_tdata  = frame_q[BYTE_W-1:0];
	assign m_axis_tuser  = err_q;
	assign take          = m_axis_tvalid && m_axis_tready;
	// free now, or the final byte leaves this cycle
	assign load_ready    = !m_axis_tvalid || (take && m_axis_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (load) begin
			left_q <= enc.count;
		end else if (take) begin
			left_q <= left_q - COUNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= enc.frame;
			err_q   <= enc.tag_error;
		end else if (take) begin
			frame_q <= frame_q >> BYTE_W;
		end
	end

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking bench for tagged_scalar_field_encoder_core
// depends on tsfe_pkg and the encoder rtl; predicts every encoded byte and
// compares each result word in order, with random stalls on both streams
`timescale 1ns / 1ps

module tb_top
	import tsfe_pkg::*;
;

	localparam int TAG_LIMIT  = 256;
	localparam int HOLD_LEN   = 300;

	// one predicted result word
	typedef struct packed {
		logic [7:0] bval;
		logic       last;
		logic       err;
	} enc_word_t;

	// holds the predicted byte stream and compares the block's words with it
	class field_scoreboard;
		enc_word_t want_q[$];
		int n_fields;
		int n_rejected;
		int n_words;
		int n_bad;

		function bit fits_signed(logic [63:0] s, int bits);
			logic [63:0] hi;
			hi = $signed(s) >>> (bits - 1);
			return (hi == '0) || (hi == '1);
		endfunction

		function void push_word(logic [7:0] b, logic l, logic e);
			want_q.push_back(enc_word_t'{bval: b, last: l, err: e});
		endfunction

		// work out the encoding of one accepted field
		function void note_field(logic [15:0] tag, logic [2:0] kind, logic [63:0] raw);
			logic [63:0] s;
			logic [63:0] pay;
			type_code_t  tc;
			int          nb;
			n_fields++;
			// oversized tag or unknown kind: a single error word
			if (tag >= TAG_LIMIT || kind > KIND_DOUBLE) begin
				push_word(8'h00, 1'b1, 1'b1);
				n_rejected++;
				return;
			end
			if (kind == KIND_FLOAT) begin
				tc  = TYPE_FLOAT;
				nb  = 4;
				pay = {32'b0, raw[31:0]};
			end else if (kind == KIND_DOUBLE) begin
				tc  = TYPE_DOUBLE;
				nb  = 8;
				pay = raw;
			end else begin
				case (kind)
					KIND_U8:  s = {56'b0, raw[7:0]};
					KIND_S16: s = {{48{raw[15]}}, raw[15:0]};
					KIND_S32: s = {{32{raw[31]}}, raw[31:0]};
					default:  s = raw;
				endcase
				// narrowest class whose signed range holds the value
				if (kind == KIND_S64 && !fits_signed(s, 32)) begin
					tc = TYPE_LONG;
					nb = 8;
				end else if (kind >= KIND_S32 && !fits_signed(s, 16)) begin
					tc = TYPE_INT;
					nb = 4;
				end else if (kind >= KIND_S16 && !fits_signed(s, 8)) begin
					tc = TYPE_SHORT;
					nb = 2;
				end else if (s[7:0] == 8'h00) begin
					tc = TYPE_ZERO;
					nb = 0;
				end else begin
					tc = TYPE_BYTE;
					nb = 1;
				end
				pay = s;
			end
			if (tag < SHORT_TAG_LIMIT) begin
				push_word({tag[3:0], tc}, nb == 0, 1'b0);
			end else begin
				push_word(LONG_TAG_MARK | {4'b0, tc}, 1'b0, 1'b0);
				push_word(tag[7:0], nb == 0, 1'b0);
			end
			for (int i = 0; i < nb; i++)
				push_word(pay[8*i +: 8], i == nb - 1, 1'b0);
		endfunction

		function void check_word(logic [7:0] b, logic l, logic e);
			enc_word_t w;
			n_words++;
			if (want_q.size() == 0) begin
				$error("unexpected word: out_byte %02h last_byte %0b tag_error %0b", b, l, e);
				n_bad++;
				return;
			end
			w = want_q.pop_front();
			if (b !== w.bval) begin
				$error("out_byte: expected %02h, actual %02h", w.bval, b);
				n_bad++;
			end
			if (l !== w.last) begin
				$error("last_byte: expected %0b, actual %0b", w.last, l);
				n_bad++;
			end
			if (e !== w.err) begin
				$error("tag_error: expected %0b, actual %0b", w.err, e);
				n_bad++;
			end
		endfunction

		function int pending();
			return want_q.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [BYTE_W-1:0]    m_axis_tdata;
	logic                 m_axis_tlast;
	logic                 m_axis_tuser;

	field_scoreboard sb = new();

	bit no_idle  = 1'b0;   // both sides stream without gaps
	bit hold_req = 1'b0;   // asks the receiver for a long hold-off
	int hold_left = 0;

	tagged_scalar_field_encoder_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: random stalls, plus a counted hold-off when asked
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_LEN;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				m_axis_tready = 1'b0;
				hold_left--;
			end else begin
				m_axis_tready = no_idle || ($urandom_range(99) >= 32);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser);
	end

	// offer one field and wait until it is taken
	task automatic send_field(input logic [15:0] tag, input logic [2:0] kind,
			input logic [63:0] raw);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 32) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tdata  = {5'b0, raw, kind, tag};
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_field(tag, kind, raw);
	endtask

	// sender stops and waits for every predicted word to come out
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_tag();
		int sel;
		sel = $urandom_range(19);
		if (sel < 9)       return 16'($urandom_range(14));
		else if (sel < 17) return 16'($urandom_range(255, 15));
		else if (sel < 19) return 16'($urandom_range(65535, 256));
		else               return 16'($urandom);
	endfunction

	function automatic logic [2:0] rand_kind();
		if ($urandom_range(19) == 0) return 3'($urandom_range(7, 6));
		return 3'($urandom_range(5));
	endfunction

	// mostly values cut to a random signed width or near powers of two, so every width is reached
	function automatic logic [63:0] rand_raw();
		logic [63:0] r;
		int sel;
		int w;
		r   = {$urandom, $urandom};
		sel = $urandom_range(9);
		w   = $urandom_range(64, 1);
		if (sel < 5) begin
			r = $signed(r << (64 - w)) >>> (64 - w);
		end else if (sel == 6) begin
			r[31:0] = 32'h0;
		end else if (sel > 6) begin
			r = (64'd1 << $urandom_range(63)) + 64'($urandom_range(2)) - 64'd1;
			if ($urandom_range(1)) r = -r;
		end
		return r;
	endfunction

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++)
			send_field(rand_tag(), rand_kind(), rand_raw());
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: tag edges, every kind, class boundaries, zero reduction
		send_field(16'd0,     KIND_U8,     64'h0);
		send_field(16'd14,    KIND_U8,     64'hFF);
		send_field(16'd15,    KIND_U8,     64'hFFFF_FFFF_FFFF_FF00);
		send_field(16'd255,   KIND_U8,     64'h7F);
		send_field(16'd256,   KIND_U8,     64'h12);
		send_field(16'd65535, KIND_DOUBLE, 64'h1);
		send_field(16'd3,     KIND_S16,    64'hFFFF);
		send_field(16'd7,     KIND_S16,    64'h0080);
		send_field(16'd200,   KIND_S16,    64'hFFFF_FFFF_FFFF_FF80);
		send_field(16'd1,     KIND_S16,    64'h8000);
		send_field(16'd2,     KIND_S16,    64'hABCD_0000);
		send_field(16'd9,     KIND_S32,    64'h7FFF_FFFF);
		send_field(16'd16,    KIND_S32,    64'h0000_7FFF);
		send_field(16'd5,     KIND_S32,    64'hFFFF_8000);
		send_field(16'd6,     KIND_S32,    64'h0000_8000);
		send_field(16'd8,     KIND_S64,    64'h8000_0000_0000_0000);
		send_field(16'd100,   KIND_S64,    64'h0000_0000_7FFF_FFFF);
		send_field(16'd11,    KIND_S64,    64'hFFFF_FFFF_8000_0000);
		send_field(16'd12,    KIND_S64,    64'h0000_0000_8000_0000);
		send_field(16'd13,    KIND_S64,    64'h0);
		send_field(16'd254,   KIND_S64,    64'hFFFF_FFFF_FFFF_FF00);
		send_field(16'd4,     KIND_FLOAT,  64'hFFFF_FFFF_1234_5678);
		send_field(16'd0,     KIND_FLOAT,  64'h0);
		send_field(16'd10,    KIND_DOUBLE, 64'hFFFF_FFFF_FFFF_FFFF);
		send_field(16'd1,     3'd6,        64'h55);
		send_field(16'd40,    3'd7,        64'hAA);
		wait_drained();

		send_random(160);

		// stretch with no gaps on either side
		no_idle = 1'b1;
		send_random(120);
		no_idle = 1'b0;

		// receiver holds off while fields keep coming, so the input backs up
		hold_req = 1'b1;
		send_random(60);
		wait_drained();

		send_random(140);

		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d fields (%0d rejected for tag or kind), %0d result words compared",
			sb.n_fields, sb.n_rejected, sb.n_words);
		$display("short and long tag heads, all integer classes, zero heads, float and double");
		if (sb.n_bad == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// watchdog
	initial begin
		#1_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
